[rtl/ffba_pkg.sv]
// ffba_pkg: shared types and constants of the first-fit block allocator.
// Used by ffba_match and first_fit_block_allocator; depends on nothing.
package ffba_pkg;

	// operation codes carried in the input item
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CHECK = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// configuration register index (paddr[2])
	localparam logic REG_REGION_SIZE = 1'b0;

	localparam int          SIZE_WORD_BYTES = 4;
	localparam logic [15:0] REGION_RESET    = 16'd4096;

	// one row of the block table
	typedef struct packed {
		logic        is_free;
		logic [15:0] bytes;
		logic [15:0] offset;
	} entry_t;

	// what the compare unit looks for during a table scan
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] req_bytes;
		logic [15:0] handle;
	} match_key_t;

endpackage

[rtl/ffba_ram.sv]
// ffba_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ffba_match.sv]
// ffba_match: compare unit shared by all table scans; tests one entry
// against the key of the current operation. Depends on ffba_pkg.
module ffba_match import ffba_pkg::*; (
	input  match_key_t key,
	input  entry_t     ent,
	output logic       hit
);

	always_comb begin
		unique case (key.op)
			OP_ALLOC: hit = ent.is_free &&
				(ent.bytes == 16'd0 || ent.bytes >= key.req_bytes);
			OP_FREE:  hit = (ent.offset == key.handle) && !ent.is_free;
			OP_CHECK: hit = (ent.offset == key.handle);
			default:  hit = 1'b0;
		endcase
	end

endmodule

[rtl/first_fit_block_allocator.sv]
// first_fit_block_allocator: top level, sequencer, APB register and output stage.
// Depends on ffba_pkg, ffba_ram and ffba_match.
//
// Usage:
//  s_tdata item (operation, request_bytes, handle) starts one operation:
//  allocate, free or check. s_tready is high only while the sequencer is
//  idle; one item is worked on at a time.
//  Each operation scans the block table in address order, one entry per
//  cycle through the table RAM read port and the shared compare unit.
//  The accepted item goes to the scan state, which runs until an entry
//  matches or the table ends; a match passes the hit state (and, for a
//  successful allocate, the append state) before the response state. A
//  zero-size allocate or code 3 goes straight to the response state. The
//  sequencer returns to idle as the result is loaded.
//  The result item sits in an output register; if the receiver stalls,
//  the next result waits in the response state until m_tvalid clears.
//  Reset (or a write of region_size) restarts the table to one unused
//  free block; no clearing pass is needed. Write region_size only while
//  idle. pready is always high.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int MAX_BLOCKS   = 64,
	parameter int HEADER_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // operation[1:0], request_bytes[17:2], handle[33:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // ok[0], granted_offset[16:1]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = $bits(entry_t);
	localparam logic [16:0]   OVERHEAD     = 17'(SIZE_WORD_BYTES + HEADER_BYTES);
	localparam logic [15:0]   FIRST_OFFSET = 16'(SIZE_WORD_BYTES + HEADER_BYTES);
	localparam logic [15:0]   APPEND_MIN   = 16'(HEADER_BYTES + 1);
	localparam logic [15:0]   HDR16        = 16'(HEADER_BYTES);
	localparam logic [CW-1:0] COUNT_MAX    = CW'(MAX_BLOCKS);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_HIT    = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_RESP   = 3'd4;

	function automatic logic [15:0] restart_free(input logic [15:0] region);
		logic [16:0] r;
		r = {1'b0, region};
		return (r >= OVERHEAD) ? 16'(r - OVERHEAD) : 16'd0;
	endfunction

	logic [2:0]    state_q;
	logic [15:0]   region_q;
	logic [15:0]   free_q;
	logic [CW-1:0] count_q;
	logic          fresh0_q;
	match_key_t    key_q;
	logic [CW-1:0] iss_q;
	logic          vld_s1;
	logic [IW-1:0] ev_s1;
	logic [IW-1:0] hit_idx_q;
	entry_t        hit_ent_q;
	logic          res_ok_q;
	logic [15:0]   res_off_q;
	logic          m_valid_q;
	logic [16:0]   m_data_q;

	logic          issue;
	logic          hit;
	logic          cfg_wr;
	logic          alloc_fits;
	logic          do_append;
	logic [16:0]   end_sum;
	logic [16:0]   free_sum;
	logic [17:0]   next_sum;
	logic [15:0]   next_off;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [EW-1:0] ram_rdata;
	entry_t        eval_ent;

	// table memory
	ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (iss_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// entry zero reads as its restart value until written
	always_comb begin
		if (fresh0_q && ev_s1 == '0) begin
			eval_ent = '{is_free: 1'b1, bytes: 16'd0, offset: FIRST_OFFSET};
		end else begin
			eval_ent = entry_t'(ram_rdata);
		end
	end

	ffba_match u_match (
		.key (key_q),
		.ent (eval_ent),
		.hit (hit)
	);

	// scan issue and update arithmetic
	always_comb begin
		issue      = (state_q == ST_SCAN) && (iss_q < count_q);
		end_sum    = {1'b0, hit_ent_q.offset} + {1'b0, key_q.req_bytes};
		alloc_fits = (free_q >= key_q.req_bytes) && (end_sum <= {1'b0, region_q});
		free_sum   = {1'b0, free_q} + {1'b0, hit_ent_q.bytes};
		next_sum   = {2'b0, hit_ent_q.offset} + {2'b0, key_q.req_bytes} + {2'b0, HDR16};
		next_off   = (next_sum > 18'h0FFFF) ? 16'hFFFF : next_sum[15:0];
		do_append  = (CW'(hit_idx_q) + CW'(1) == count_q) && (count_q < COUNT_MAX) &&
			(free_q > APPEND_MIN);
		cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_REGION_SIZE);
	end

	// table write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = '{is_free: 1'b1, bytes: hit_ent_q.bytes, offset: hit_ent_q.offset};
		if (state_q == ST_HIT && key_q.op == OP_ALLOC) begin
			ram_we    = alloc_fits;
			ram_wdata = '{is_free: 1'b0, bytes: key_q.req_bytes, offset: hit_ent_q.offset};
		end else if (state_q == ST_HIT && key_q.op == OP_FREE) begin
			ram_we = 1'b1;
		end else if (state_q == ST_APPEND) begin
			ram_we    = do_append;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = '{is_free: 1'b1, bytes: 16'd0, offset: next_off};
		end
	end

	// sequencer, table bookkeeping and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			region_q  <= REGION_RESET;
			free_q    <= restart_free(REGION_RESET);
			count_q   <= CW'(1);
			fresh0_q  <= 1'b1;
			iss_q     <= '0;
			vld_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (ram_we && ram_waddr == '0) begin
				fresh0_q <= 1'b0;
			end
			if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				region_q <= pwdata[15:0];
				free_q   <= restart_free(pwdata[15:0]);
				count_q  <= CW'(1);
				fresh0_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						key_q  <= '{op: s_tdata[1:0], req_bytes: s_tdata[17:2],
							handle: s_tdata[33:18]};
						iss_q  <= '0;
						vld_s1 <= 1'b0;
						if ((s_tdata[1:0] == OP_ALLOC && s_tdata[17:2] == 16'd0) ||
							s_tdata[1:0] == OP_NONE) begin
							res_ok_q  <= 1'b0;
							res_off_q <= 16'd0;
							state_q   <= ST_RESP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (vld_s1 && hit) begin
						hit_idx_q <= ev_s1;
						hit_ent_q <= eval_ent;
						vld_s1    <= 1'b0;
						state_q   <= ST_HIT;
					end else if (!vld_s1 && iss_q >= count_q) begin
						res_ok_q  <= 1'b0;
						res_off_q <= 16'd0;
						state_q   <= ST_RESP;
					end else begin
						vld_s1 <= issue;
						ev_s1  <= iss_q[IW-1:0];
						if (issue) begin
							iss_q <= iss_q + CW'(1);
						end
					end
				end
				ST_HIT: begin
					res_off_q <= 16'd0;
					res_ok_q  <= 1'b1;
					state_q   <= ST_RESP;
					unique case (key_q.op)
						OP_ALLOC: begin
							if (alloc_fits) begin
								free_q    <= free_q - key_q.req_bytes;
								res_off_q <= hit_ent_q.offset;
								state_q   <= ST_APPEND;
							end else begin
								res_ok_q <= 1'b0;
							end
						end
						OP_FREE: begin
							free_q <= free_sum[16] ? 16'hFFFF : free_sum[15:0];
						end
						default: begin
						end
					endcase
				end
				ST_APPEND: begin
					if (do_append) begin
						free_q  <= free_q - HDR16;
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {res_off_q, res_ok_q};
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ports
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_data_q};
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_REGION_SIZE) ? {16'd0, region_q} : 32'd0;

	// block count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(1) && count_q <= COUNT_MAX)
		else $error("block count out of range");

	// the table is only written while an operation is in progress
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != ST_IDLE)
		else $error("table write while idle");

	// an accepted item makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accept");

	// a new result only appears out of the response state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_RESP))
		else $error("result loaded outside the response state");

endmodule
